// File: hdl/btda_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// btda_pkg
// Shared constants and helpers for the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package btda_pkg;

    // One BCD digit is a nibble
    localparam int unsigned DIGIT_W = 4;

    // ASCII code of '0' as carried on the 6-bit character field
    localparam logic [5:0] ASCII_ZERO = 6'd48;

    // Width of the character field on the output
    localparam int unsigned CHAR_W = 6;

    // Double-dabble correction: a digit of 5 or more gets 3 added
    // before the next left shift so that it carries into the next digit.
    function automatic logic [DIGIT_W-1:0] bcd_adjust(input logic [DIGIT_W-1:0] d);
        logic [DIGIT_W-1:0] res;
        res = (d >= 4'd5) ? d + 4'd3 : d;
        return res;
    endfunction

endpackage : btda_pkg
`default_nettype wire

// File: hdl/btda_dabble.sv
`default_nettype none
// ----------------------------------------------------------------------------
// btda_dabble
// Bit-serial double-dabble converter: shifts one binary bit per cycle into a
// packed BCD register and hands the finished digits to the emitter.
// ----------------------------------------------------------------------------
module btda_dabble #(
    parameter int unsigned VALUE_BITS = 32,
    parameter int unsigned NUM_DIGITS = 10
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // binary value in
    input  wire logic                                   i_valid,
    output logic                                        o_ready,
    input  wire logic [VALUE_BITS-1:0]                  i_value,
    // packed BCD out, most significant digit in the top nibble
    output logic                                        o_bcd_valid,
    input  wire logic                                   i_bcd_ready,
    output logic [NUM_DIGITS*btda_pkg::DIGIT_W-1:0]     o_bcd
);
    import btda_pkg::*;

    localparam int unsigned BCD_W = NUM_DIGITS * DIGIT_W;
    localparam int unsigned CNT_W = $clog2(VALUE_BITS + 1);
    localparam logic [CNT_W-1:0] CNT_LOAD = CNT_W'(VALUE_BITS);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SHIFT = 2'd1;
    localparam logic [1:0] ST_DONE  = 2'd2;

    logic [1:0]            r_state, n_state;
    logic [CNT_W-1:0]      r_cnt,   n_cnt;
    logic [VALUE_BITS-1:0] r_bin,   n_bin;
    logic [BCD_W-1:0]      r_bcd,   n_bcd;
    logic [BCD_W-1:0]      w_adj;

    // Per-digit correction ahead of the shift
    for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_adj
        assign w_adj[g*DIGIT_W +: DIGIT_W] = bcd_adjust(r_bcd[g*DIGIT_W +: DIGIT_W]);
    end

    // Sequencer: load, shift VALUE_BITS times, hold until taken
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_bin   = r_bin;
        n_bcd   = r_bcd;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_bin   = i_value;
                    n_bcd   = '0;
                    n_cnt   = CNT_LOAD;
                    n_state = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                n_bcd = {w_adj[BCD_W-2:0], r_bin[VALUE_BITS-1]};
                n_bin = {r_bin[VALUE_BITS-2:0], 1'b0};
                n_cnt = r_cnt - CNT_ONE;
                if (r_cnt == CNT_ONE) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_bcd_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_bin <= n_bin;
        r_bcd <= n_bcd;
    end

    assign o_ready     = (r_state == ST_IDLE);
    assign o_bcd_valid = (r_state == ST_DONE);
    assign o_bcd       = r_bcd;

    // Checks
    a_shift_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SHIFT |-> r_cnt != '0)
        else $error("shift state with zero bit count");

    a_load_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_valid) |=> (r_state == ST_SHIFT && r_cnt == CNT_LOAD))
        else $error("accepted value did not start a conversion");

    a_done_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && !i_bcd_ready) |=> (r_state == ST_DONE && $stable(r_bcd)))
        else $error("BCD result changed before it was taken");

endmodule : btda_dabble
`default_nettype wire

// File: hdl/btda_emit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// btda_emit
// Digit emitter: skips leading zeros, then shifts the BCD word out one nibble
// per cycle unless the output stalls, driving the registered character stream.
// ----------------------------------------------------------------------------
module btda_emit #(
    parameter int unsigned NUM_DIGITS = 10
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // packed BCD in
    input  wire logic                                   i_bcd_valid,
    output logic                                        o_bcd_ready,
    input  wire logic [NUM_DIGITS*btda_pkg::DIGIT_W-1:0] i_bcd,
    // character stream out
    output logic                                        o_tvalid,
    input  wire logic                                   i_tready,
    output logic [btda_pkg::CHAR_W-1:0]                 o_char,
    output logic                                        o_last
);
    import btda_pkg::*;

    localparam int unsigned BCD_W = NUM_DIGITS * DIGIT_W;
    localparam int unsigned CNT_W = $clog2(NUM_DIGITS + 1);
    localparam logic [CNT_W-1:0] CNT_LOAD = CNT_W'(NUM_DIGITS);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_ACTIVE = 1'b1;

    logic               r_state,   n_state;
    logic [CNT_W-1:0]   r_count,   n_count;
    logic               r_started, n_started;
    logic [BCD_W-1:0]   r_digits,  n_digits;
    logic               r_tvalid,  n_tvalid;
    logic [CHAR_W-1:0]  r_char,    n_char;
    logic               r_last,    n_last;
    logic [DIGIT_W-1:0] w_top;
    logic               w_out_free;

    assign w_top      = r_digits[BCD_W-1 -: DIGIT_W];
    assign w_out_free = !r_tvalid || i_tready;

    // Skip leading zeros, then move one digit per free output slot
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_started = r_started;
        n_digits  = r_digits;
        n_tvalid  = r_tvalid && !i_tready;
        n_char    = r_char;
        n_last    = r_last;
        case (r_state)
            ST_IDLE: begin
                if (i_bcd_valid) begin
                    n_digits  = i_bcd;
                    n_count   = CNT_LOAD;
                    n_started = 1'b0;
                    n_state   = ST_ACTIVE;
                end
            end
            ST_ACTIVE: begin
                if (!r_started && w_top == '0 && r_count != CNT_ONE) begin
                    n_digits = {r_digits[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                    n_count  = r_count - CNT_ONE;
                end else if (w_out_free) begin
                    n_tvalid  = 1'b1;
                    n_char    = ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, w_top};
                    n_last    = (r_count == CNT_ONE);
                    n_digits  = {r_digits[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                    n_count   = r_count - CNT_ONE;
                    n_started = 1'b1;
                    if (r_count == CNT_ONE) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_started <= 1'b0;
            r_tvalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_started <= n_started;
            r_tvalid  <= n_tvalid;
        end
        r_digits <= n_digits;
        r_char   <= n_char;
        r_last   <= n_last;
    end

    assign o_bcd_ready = (r_state == ST_IDLE);
    assign o_tvalid    = r_tvalid;
    assign o_char      = r_char;
    assign o_last      = r_last;

    // Checks
    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tvalid |-> (r_char >= ASCII_ZERO && r_char <= ASCII_ZERO + 6'd9))
        else $error("output character is not a decimal digit");

    a_active_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_ACTIVE |-> r_count != '0)
        else $error("emitter active with no digits left");

    a_no_lead_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ACTIVE && !r_started && n_tvalid && !(r_tvalid && !i_tready))
        |-> (w_top != '0 || r_count == CNT_ONE))
        else $error("leading zero emitted");

endmodule : btda_emit
`default_nettype wire

// File: hdl/binary_to_decimal_ascii_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_unit
// Unsigned binary to decimal ASCII digit stream, leading zeros suppressed.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel takes one unsigned number per transfer in tdata; only the
//   low VALUE_BITS bits are converted. Master channel gives one ASCII digit
//   per transfer, most significant first, tlast on the least significant.
//   A zero value gives the single character '0'.
// Timing:
//   The converter loads the value, then shifts one bit per cycle and hands
//   its result off to the emitter. The emitter then skips one leading zero
//   per cycle and sends one digit per cycle unless the output stalls.
//   The next value is taken as soon as the converter has handed its result
//   to the emitter, so conversion overlaps emission; sustained, the value
//   rate is bounded by the bit-serial shift loop.
// Reset: synchronous, active low; both channels go idle, no state is kept.
// Stall: the output character is registered; while tready is low it holds,
//   the emitter waits and the converter holds its finished result, then
//   deasserts s_axis tready until the emitter takes it.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_unit #(
    parameter int unsigned VALUE_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // slave stream
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [31:0] i_s_axis_tdata,   // [31:0] value
    // master stream
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [7:0]       o_m_axis_tdata,   // [5:0] digit_char, [7:6] zero
    output logic             o_m_axis_tlast    // last_digit
);
    import btda_pkg::*;

    // Decimal digits needed for VALUE_BITS bits: floor(bits * log10(2)) + 1
    localparam int unsigned NUM_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int unsigned BCD_W      = NUM_DIGITS * DIGIT_W;

    logic              w_bcd_valid;
    logic              w_bcd_ready;
    logic [BCD_W-1:0]  w_bcd;
    logic [CHAR_W-1:0] w_char;

    btda_dabble #(
        .VALUE_BITS (VALUE_BITS),
        .NUM_DIGITS (NUM_DIGITS)
    ) u_dabble (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_value     (i_s_axis_tdata[VALUE_BITS-1:0]),
        .o_bcd_valid (w_bcd_valid),
        .i_bcd_ready (w_bcd_ready),
        .o_bcd       (w_bcd)
    );

    btda_emit #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_bcd_valid (w_bcd_valid),
        .o_bcd_ready (w_bcd_ready),
        .i_bcd       (w_bcd),
        .o_tvalid    (o_m_axis_tvalid),
        .i_tready    (i_m_axis_tready),
        .o_char      (w_char),
        .o_last      (o_m_axis_tlast)
    );

    // Pad the character to a whole byte
    assign o_m_axis_tdata = {{(8-CHAR_W){1'b0}}, w_char};

endmodule : binary_to_decimal_ascii_unit
`default_nettype wire
